### rtl/assert_macros.svh
// Assertion macros used by the decoder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/msid_pkg.sv
// Package: opcodes, function codes, operation numbers and decode result type.
`default_nettype none
package msid_pkg;

  localparam int unsigned WordW = 32;

  // Operation class codes
  localparam logic [1:0] CLS_NORMAL  = 2'd0;
  localparam logic [1:0] CLS_BRANCH  = 2'd1;
  localparam logic [1:0] CLS_SYSCALL = 2'd2;
  localparam logic [1:0] CLS_SYNC    = 2'd3;

  // Major opcodes, bits 31..26
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTIU   = 6'h0B;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_COP0    = 6'h10;
  localparam logic [5:0] OPC_COP1    = 6'h11;
  localparam logic [5:0] OPC_BEQL    = 6'h14;
  localparam logic [5:0] OPC_SQ      = 6'h1F;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_LBU     = 6'h24;
  localparam logic [5:0] OPC_LHU     = 6'h25;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2B;
  localparam logic [5:0] OPC_LWC1    = 6'h31;
  localparam logic [5:0] OPC_LD      = 6'h37;
  localparam logic [5:0] OPC_SWC1    = 6'h39;
  localparam logic [5:0] OPC_SD      = 6'h3F;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_SYNC    = 6'h0F;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_SLTU    = 6'h2B;
  localparam logic [5:0] FN_DADDU   = 6'h2D;
  localparam logic [5:0] FN_DSLL    = 6'h38;
  localparam logic [5:0] FN_DSRL    = 6'h3A;
  localparam logic [5:0] FN_DSLL32  = 6'h3C;

  // REGIMM rt codes
  localparam logic [4:0] RT_BLTZ = 5'd0;
  localparam logic [4:0] RT_BGEZ = 5'd1;

  // COP1 rs codes for register moves, and function codes
  localparam logic [4:0] RS_MFC1 = 5'd0;
  localparam logic [4:0] RS_MTC1 = 5'd4;
  localparam logic [5:0] FN1_MOVE  = 6'h00;
  localparam logic [5:0] FN1_MULS  = 6'h02;
  localparam logic [5:0] FN1_DIVS  = 6'h03;
  localparam logic [5:0] FN1_MOVS  = 6'h06;
  localparam logic [5:0] FN1_CVTSW = 6'h20;
  localparam logic [5:0] FN1_CVTWS = 6'h24;

  // Dense operation numbers
  typedef enum logic [5:0] {
    OP_SLL, OP_SLTU, OP_DADDU, OP_MULT, OP_ADDU, OP_AND, OP_DSRL, OP_SRL,
    OP_DSLL, OP_OR, OP_DSLL32, OP_DIVU, OP_MFHI, OP_BREAK, OP_SRA, OP_SYSCALL,
    OP_SYNC, OP_JR, OP_BLTZ, OP_BGEZ, OP_MTC1, OP_MFC1, OP_CVTSW, OP_CVTWS,
    OP_DIVS, OP_MOVS, OP_MULS, OP_LUI, OP_ADDIU, OP_SQ, OP_EI, OP_LW,
    OP_SD, OP_SW, OP_LHU, OP_SH, OP_ORI, OP_LD, OP_ANDI, OP_LBU,
    OP_SB, OP_SLTIU, OP_SWC1, OP_LWC1, OP_BNE, OP_BEQ, OP_J, OP_JAL
  } op_e;

  // One decoded word
  typedef struct packed {
    logic [5:0]  op_id;
    logic [1:0]  op_class;
    logic        likely;
    logic        illegal;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  funct;
    logic [15:0] imm;
    logic [25:0] target;
  } dec_t;

endpackage
`default_nettype wire

### rtl/msid_decode.sv
// Combinational decode of one instruction word into fields and operation number.
`default_nettype none
module msid_decode
  import msid_pkg::*;
(
  input  wire logic [WordW-1:0] word,
  output dec_t                  dec
);

  logic [5:0] opc;
  logic [5:0] op_num;
  logic [1:0] cls;
  logic       lk;
  logic       ok;

  assign opc = word[31:26];

  // Operation match
  always_comb begin
    op_num = 6'(OP_SLL);
    cls    = CLS_NORMAL;
    lk     = 1'b0;
    ok     = 1'b1;
    unique case (opc)
      OPC_SPECIAL: begin
        unique case (word[5:0])
          FN_SLL:     op_num = 6'(OP_SLL);
          FN_SLTU:    op_num = 6'(OP_SLTU);
          FN_DADDU:   op_num = 6'(OP_DADDU);
          FN_MULT:    op_num = 6'(OP_MULT);
          FN_ADDU:    op_num = 6'(OP_ADDU);
          FN_AND:     op_num = 6'(OP_AND);
          FN_DSRL:    op_num = 6'(OP_DSRL);
          FN_SRL:     op_num = 6'(OP_SRL);
          FN_DSLL:    op_num = 6'(OP_DSLL);
          FN_OR:      op_num = 6'(OP_OR);
          FN_DSLL32:  op_num = 6'(OP_DSLL32);
          FN_DIVU:    op_num = 6'(OP_DIVU);
          FN_MFHI:    op_num = 6'(OP_MFHI);
          FN_BREAK:   op_num = 6'(OP_BREAK);
          FN_SRA:     op_num = 6'(OP_SRA);
          FN_SYSCALL: begin
            op_num = 6'(OP_SYSCALL);
            cls    = CLS_SYSCALL;
          end
          FN_SYNC: begin
            op_num = 6'(OP_SYNC);
            cls    = CLS_SYNC;
          end
          FN_JR: begin
            op_num = 6'(OP_JR);
            cls    = CLS_BRANCH;
          end
          default: ok = 1'b0;
        endcase
      end
      OPC_REGIMM: begin
        unique case (word[20:16])
          RT_BLTZ: begin
            op_num = 6'(OP_BLTZ);
            cls    = CLS_BRANCH;
          end
          RT_BGEZ: begin
            op_num = 6'(OP_BGEZ);
            cls    = CLS_BRANCH;
          end
          default: ok = 1'b0;
        endcase
      end
      OPC_COP1: begin
        unique case (word[5:0])
          // register moves need the low 11 bits clear
          FN1_MOVE: begin
            if (word[10:0] != 11'd0) begin
              ok = 1'b0;
            end else if (word[25:21] == RS_MTC1) begin
              op_num = 6'(OP_MTC1);
            end else if (word[25:21] == RS_MFC1) begin
              op_num = 6'(OP_MFC1);
            end else begin
              ok = 1'b0;
            end
          end
          FN1_CVTSW: op_num = 6'(OP_CVTSW);
          FN1_CVTWS: op_num = 6'(OP_CVTWS);
          FN1_DIVS:  op_num = 6'(OP_DIVS);
          FN1_MOVS:  op_num = 6'(OP_MOVS);
          FN1_MULS:  op_num = 6'(OP_MULS);
          default:   ok = 1'b0;
        endcase
      end
      OPC_LUI:   op_num = 6'(OP_LUI);
      OPC_ADDIU: op_num = 6'(OP_ADDIU);
      OPC_SQ:    op_num = 6'(OP_SQ);
      OPC_COP0:  op_num = 6'(OP_EI);
      OPC_LW:    op_num = 6'(OP_LW);
      OPC_SD:    op_num = 6'(OP_SD);
      OPC_SW:    op_num = 6'(OP_SW);
      OPC_LHU:   op_num = 6'(OP_LHU);
      OPC_SH:    op_num = 6'(OP_SH);
      OPC_ORI:   op_num = 6'(OP_ORI);
      OPC_LD:    op_num = 6'(OP_LD);
      OPC_ANDI:  op_num = 6'(OP_ANDI);
      OPC_LBU:   op_num = 6'(OP_LBU);
      OPC_SB:    op_num = 6'(OP_SB);
      OPC_SLTIU: op_num = 6'(OP_SLTIU);
      OPC_SWC1:  op_num = 6'(OP_SWC1);
      OPC_LWC1:  op_num = 6'(OP_LWC1);
      OPC_BNE: begin
        op_num = 6'(OP_BNE);
        cls    = CLS_BRANCH;
      end
      OPC_BEQ: begin
        op_num = 6'(OP_BEQ);
        cls    = CLS_BRANCH;
      end
      // likely form shares the BEQ number
      OPC_BEQL: begin
        op_num = 6'(OP_BEQ);
        cls    = CLS_BRANCH;
        lk     = 1'b1;
      end
      OPC_J: begin
        op_num = 6'(OP_J);
        cls    = CLS_BRANCH;
      end
      OPC_JAL: begin
        op_num = 6'(OP_JAL);
        cls    = CLS_BRANCH;
      end
      default: ok = 1'b0;
    endcase
  end

  // Result; illegal words report operation zero, class normal
  always_comb begin
    dec.op_id    = ok ? op_num : 6'(OP_SLL);
    dec.op_class = ok ? cls : CLS_NORMAL;
    dec.likely   = ok & lk;
    dec.illegal  = ~ok;
    dec.rs       = word[25:21];
    dec.rt       = word[20:16];
    dec.rd       = word[15:11];
    dec.sa       = word[10:6];
    dec.funct    = word[5:0];
    dec.imm      = word[15:0];
    dec.target   = word[25:0];
  end

endmodule
`default_nettype wire

### rtl/mips_subset_instruction_decoder_unit.sv
// Top level: registered instruction decoder with valid/stall channels.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   instr_word
//   out      from block out_valid / out_stall op_id .. jump_target
//
// One word per cycle sustained while out_stall is low (input register, decode,
// result register). Reset clears both valid bits; payload registers are not reset.
// A stall on the output holds the result register; the input register then
// fills and in_stall rises only when both stages hold a word.
`default_nettype none
module mips_subset_instruction_decoder_unit
  import msid_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WordW-1:0] instr_word,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [5:0]            op_id,
  output logic [1:0]            op_class,
  output logic                  likely_flag,
  output logic                  illegal_flag,
  output logic [4:0]            src_reg,
  output logic [4:0]            tgt_reg,
  output logic [4:0]            dst_reg,
  output logic [4:0]            shift_amt,
  output logic [5:0]            func_code,
  output logic [15:0]           imm16,
  output logic [25:0]           jump_target
);

  logic             word_vld;
  logic [WordW-1:0] word_q;
  logic             res_vld;
  dec_t             res_q;
  dec_t             dec;
  logic             res_take;

  // Stage control
  assign res_take = ~res_vld | ~out_stall;
  assign in_stall = word_vld & ~res_take;

  msid_decode u_dec (
    .word (word_q),
    .dec  (dec)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= 1'b0;
    end else if (!in_stall) begin
      word_vld <= in_valid;
    end
    if (!in_stall && in_valid) begin
      word_q <= instr_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (res_take) begin
      res_vld <= word_vld;
    end
    if (res_take && word_vld) begin
      res_q <= dec;
    end
  end

  assign out_valid    = res_vld;
  assign op_id        = res_q.op_id;
  assign op_class     = res_q.op_class;
  assign likely_flag  = res_q.likely;
  assign illegal_flag = res_q.illegal;
  assign src_reg      = res_q.rs;
  assign tgt_reg      = res_q.rt;
  assign dst_reg      = res_q.rd;
  assign shift_amt    = res_q.sa;
  assign func_code    = res_q.funct;
  assign imm16        = res_q.imm;
  assign jump_target  = res_q.target;

endmodule
`default_nettype wire

### rtl/msid_checker.sv
// Port-level checker for the decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module msid_checker
  import msid_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [WordW-1:0] instr_word,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [5:0]       op_id,
  input wire logic [1:0]       op_class,
  input wire logic             likely_flag,
  input wire logic             illegal_flag,
  input wire logic [4:0]       src_reg,
  input wire logic [4:0]       tgt_reg,
  input wire logic [4:0]       dst_reg,
  input wire logic [4:0]       shift_amt,
  input wire logic [5:0]       func_code,
  input wire logic [15:0]      imm16,
  input wire logic [25:0]      jump_target
);

  // a held result word keeps its payload
  `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(op_id) && $stable(jump_target))

  // illegal words carry no operation, class or likely mark
  `ASSERT_IMPL(a_illegal, out_valid && illegal_flag, op_id == 6'(OP_SLL) && op_class == CLS_NORMAL && !likely_flag)

  // the likely mark belongs to BEQ only
  `ASSERT_IMPL(a_likely, out_valid && likely_flag, op_id == 6'(OP_BEQ) && op_class == CLS_BRANCH)

  // input backpressure comes only from a full, stalled output
  `ASSERT_IMPL(a_stall_src, in_stall, out_valid && out_stall)

  // nothing is shown right after reset
  `ASSERT_NEXT_ALWAYS(a_reset, rst, !out_valid && !in_stall)

endmodule

bind mips_subset_instruction_decoder_unit msid_checker u_msid_checker (.*);
`default_nettype wire

### tb/tb_mips_subset_instruction_decoder_unit.sv
// Testbench for the instruction decoder: directed and random words, checked against a predictor.
`timescale 1ns / 1ps
module tb_mips_subset_instruction_decoder_unit;
  import msid_pkg::*;

  // Codes the decoder must reject
  localparam logic [5:0] OPC_UNUSED = 6'h06;
  localparam logic [5:0] FN_UNUSED  = 6'h01;
  localparam logic [5:0] FN1_UNUSED = 6'h3F;
  localparam logic [4:0] RT_UNUSED  = 5'd2;
  localparam logic [4:0] RS_UNUSED  = 5'd1;

  localparam int StallLimit = 4000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [WordW-1:0] instr_word = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [5:0]       op_id;
  logic [1:0]       op_class;
  logic             likely_flag;
  logic             illegal_flag;
  logic [4:0]       src_reg;
  logic [4:0]       tgt_reg;
  logic [4:0]       dst_reg;
  logic [4:0]       shift_amt;
  logic [5:0]       func_code;
  logic [15:0]      imm16;
  logic [25:0]      jump_target;

  dec_t decoded_q[$];
  int   error_count = 0;
  int   quiet_cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  mips_subset_instruction_decoder_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .instr_word(instr_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .op_id(op_id), .op_class(op_class), .likely_flag(likely_flag),
    .illegal_flag(illegal_flag), .src_reg(src_reg), .tgt_reg(tgt_reg),
    .dst_reg(dst_reg), .shift_amt(shift_amt), .func_code(func_code),
    .imm16(imm16), .jump_target(jump_target)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected decode of one word
  function automatic dec_t decode_word(input logic [31:0] w);
    dec_t d;
    logic ok;
    d = '0;
    ok = 1'b1;
    d.op_class = CLS_NORMAL;
    case (w[31:26])
      OPC_SPECIAL: begin
        case (w[5:0])
          FN_SLL:    d.op_id = OP_SLL;
          FN_SLTU:   d.op_id = OP_SLTU;
          FN_DADDU:  d.op_id = OP_DADDU;
          FN_MULT:   d.op_id = OP_MULT;
          FN_ADDU:   d.op_id = OP_ADDU;
          FN_AND:    d.op_id = OP_AND;
          FN_DSRL:   d.op_id = OP_DSRL;
          FN_SRL:    d.op_id = OP_SRL;
          FN_DSLL:   d.op_id = OP_DSLL;
          FN_OR:     d.op_id = OP_OR;
          FN_DSLL32: d.op_id = OP_DSLL32;
          FN_DIVU:   d.op_id = OP_DIVU;
          FN_MFHI:   d.op_id = OP_MFHI;
          FN_BREAK:  d.op_id = OP_BREAK;
          FN_SRA:    d.op_id = OP_SRA;
          FN_SYSCALL: begin
            d.op_id = OP_SYSCALL;
            d.op_class = CLS_SYSCALL;
          end
          FN_SYNC: begin
            d.op_id = OP_SYNC;
            d.op_class = CLS_SYNC;
          end
          FN_JR: begin
            d.op_id = OP_JR;
            d.op_class = CLS_BRANCH;
          end
          default: ok = 1'b0;
        endcase
      end
      OPC_REGIMM: begin
        d.op_class = CLS_BRANCH;
        if (w[20:16] == RT_BLTZ) d.op_id = OP_BLTZ;
        else if (w[20:16] == RT_BGEZ) d.op_id = OP_BGEZ;
        else ok = 1'b0;
      end
      OPC_COP1: begin
        case (w[5:0])
          FN1_MOVE: begin
            // register moves need sa and funct all clear
            if (w[10:0] != '0) ok = 1'b0;
            else if (w[25:21] == RS_MTC1) d.op_id = OP_MTC1;
            else if (w[25:21] == RS_MFC1) d.op_id = OP_MFC1;
            else ok = 1'b0;
          end
          FN1_CVTSW: d.op_id = OP_CVTSW;
          FN1_CVTWS: d.op_id = OP_CVTWS;
          FN1_DIVS:  d.op_id = OP_DIVS;
          FN1_MOVS:  d.op_id = OP_MOVS;
          FN1_MULS:  d.op_id = OP_MULS;
          default: ok = 1'b0;
        endcase
      end
      OPC_LUI:   d.op_id = OP_LUI;
      OPC_ADDIU: d.op_id = OP_ADDIU;
      OPC_SQ:    d.op_id = OP_SQ;
      OPC_COP0:  d.op_id = OP_EI;
      OPC_LW:    d.op_id = OP_LW;
      OPC_SD:    d.op_id = OP_SD;
      OPC_SW:    d.op_id = OP_SW;
      OPC_LHU:   d.op_id = OP_LHU;
      OPC_SH:    d.op_id = OP_SH;
      OPC_ORI:   d.op_id = OP_ORI;
      OPC_LD:    d.op_id = OP_LD;
      OPC_ANDI:  d.op_id = OP_ANDI;
      OPC_LBU:   d.op_id = OP_LBU;
      OPC_SB:    d.op_id = OP_SB;
      OPC_SLTIU: d.op_id = OP_SLTIU;
      OPC_SWC1:  d.op_id = OP_SWC1;
      OPC_LWC1:  d.op_id = OP_LWC1;
      OPC_BNE: begin
        d.op_id = OP_BNE;
        d.op_class = CLS_BRANCH;
      end
      OPC_BEQ: begin
        d.op_id = OP_BEQ;
        d.op_class = CLS_BRANCH;
      end
      OPC_BEQL: begin
        d.op_id = OP_BEQ;
        d.op_class = CLS_BRANCH;
        d.likely = 1'b1;
      end
      OPC_J: begin
        d.op_id = OP_J;
        d.op_class = CLS_BRANCH;
      end
      OPC_JAL: begin
        d.op_id = OP_JAL;
        d.op_class = CLS_BRANCH;
      end
      default: ok = 1'b0;
    endcase
    // illegal words carry no operation, class or likely bit
    if (!ok) begin
      d.op_id = '0;
      d.op_class = CLS_NORMAL;
      d.likely = 1'b0;
    end
    d.illegal = !ok;
    d.rs = w[25:21];
    d.rt = w[20:16];
    d.rd = w[15:11];
    d.sa = w[10:6];
    d.funct = w[5:0];
    d.imm = w[15:0];
    d.target = w[25:0];
    return d;
  endfunction

  // Legal word for one of 49 forms (form equals the operation number, 48 is BEQL)
  function automatic logic [31:0] legal_word(input int unsigned form, input logic [31:0] bits);
    logic [31:0] w;
    w = bits;
    if (form <= 17) begin
      w[31:26] = OPC_SPECIAL;
      case (form)
        0:  w[5:0] = FN_SLL;
        1:  w[5:0] = FN_SLTU;
        2:  w[5:0] = FN_DADDU;
        3:  w[5:0] = FN_MULT;
        4:  w[5:0] = FN_ADDU;
        5:  w[5:0] = FN_AND;
        6:  w[5:0] = FN_DSRL;
        7:  w[5:0] = FN_SRL;
        8:  w[5:0] = FN_DSLL;
        9:  w[5:0] = FN_OR;
        10: w[5:0] = FN_DSLL32;
        11: w[5:0] = FN_DIVU;
        12: w[5:0] = FN_MFHI;
        13: w[5:0] = FN_BREAK;
        14: w[5:0] = FN_SRA;
        15: w[5:0] = FN_SYSCALL;
        16: w[5:0] = FN_SYNC;
        default: w[5:0] = FN_JR;
      endcase
    end else if (form <= 19) begin
      w[31:26] = OPC_REGIMM;
      w[20:16] = (form == 18) ? RT_BLTZ : RT_BGEZ;
    end else if (form <= 21) begin
      w[31:26] = OPC_COP1;
      w[25:21] = (form == 20) ? RS_MTC1 : RS_MFC1;
      w[10:0] = '0;
    end else if (form <= 26) begin
      w[31:26] = OPC_COP1;
      case (form)
        22: w[5:0] = FN1_CVTSW;
        23: w[5:0] = FN1_CVTWS;
        24: w[5:0] = FN1_DIVS;
        25: w[5:0] = FN1_MOVS;
        default: w[5:0] = FN1_MULS;
      endcase
    end else begin
      case (form)
        27: w[31:26] = OPC_LUI;
        28: w[31:26] = OPC_ADDIU;
        29: w[31:26] = OPC_SQ;
        30: w[31:26] = OPC_COP0;
        31: w[31:26] = OPC_LW;
        32: w[31:26] = OPC_SD;
        33: w[31:26] = OPC_SW;
        34: w[31:26] = OPC_LHU;
        35: w[31:26] = OPC_SH;
        36: w[31:26] = OPC_ORI;
        37: w[31:26] = OPC_LD;
        38: w[31:26] = OPC_ANDI;
        39: w[31:26] = OPC_LBU;
        40: w[31:26] = OPC_SB;
        41: w[31:26] = OPC_SLTIU;
        42: w[31:26] = OPC_SWC1;
        43: w[31:26] = OPC_LWC1;
        44: w[31:26] = OPC_BNE;
        45: w[31:26] = OPC_BEQ;
        46: w[31:26] = OPC_J;
        47: w[31:26] = OPC_JAL;
        default: w[31:26] = OPC_BEQL;
      endcase
    end
    return w;
  endfunction

  // Right major opcode, random subfields: mostly illegal, sometimes legal
  function automatic logic [31:0] near_miss_word(input logic [31:0] bits);
    logic [31:0] w;
    w = bits;
    case ($urandom_range(3))
      0: begin
        w[31:26] = OPC_COP1;
        w[5:0] = FN1_MOVE;
        if ($urandom_range(1) == 0) w[10:6] = '0;
      end
      1: w[31:26] = OPC_REGIMM;
      2: w[31:26] = OPC_SPECIAL;
      default: w[31:26] = OPC_COP1;
    endcase
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10) $display("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Output side: random stall
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Compare each decoded word with the oldest expectation, then record new input
  always @(posedge clk) begin
    dec_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("decoded word with nothing expected, op_id %0d", op_id);
        end else begin
          want = decoded_q.pop_front();
          check_field("op_id", want.op_id, op_id);
          check_field("op_class", want.op_class, op_class);
          check_field("likely_flag", want.likely, likely_flag);
          check_field("illegal_flag", want.illegal, illegal_flag);
          check_field("src_reg", want.rs, src_reg);
          check_field("tgt_reg", want.rt, tgt_reg);
          check_field("dst_reg", want.rd, dst_reg);
          check_field("shift_amt", want.sa, shift_amt);
          check_field("func_code", want.funct, func_code);
          check_field("imm16", want.imm, imm16);
          check_field("jump_target", want.target, jump_target);
        end
      end
      if (in_valid && !in_stall) decoded_q.push_back(decode_word(instr_word));
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one word, with random idle cycles first, and hold it until taken
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      instr_word <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    instr_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off input until every expected word is out; the first edge lets the
  // last accepted word reach the queue
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    send_word({OPC_SPECIAL, 5'h1F, 5'h1F, 5'h1F, 5'h1F, FN_JR});
    send_word({OPC_J, 26'h3FF_FFFF});
    send_word({OPC_JAL, 26'h000_0000});
    send_word({OPC_ORI, 5'h1F, 5'h00, 16'hFFFF});
    send_word({OPC_LUI, 5'h00, 5'h1F, 16'h0000});
  endtask

  task automatic test_special_cases();
    send_word({OPC_SPECIAL, 20'h0, FN_SYSCALL});
    send_word({OPC_SPECIAL, 20'h0, FN_SYNC});
    send_word({OPC_SPECIAL, 20'h0, FN_BREAK});
    send_word({OPC_SPECIAL, 20'h0, FN_UNUSED});
    // REGIMM branches and a bad rt
    send_word({OPC_REGIMM, 5'd3, RT_BLTZ, 16'h8000});
    send_word({OPC_REGIMM, 5'd3, RT_BGEZ, 16'h7FFF});
    send_word({OPC_REGIMM, 5'd3, RT_UNUSED, 16'h0000});
    // COP1 moves: rd may be anything, sa and funct must be clear
    send_word({OPC_COP1, RS_MTC1, 5'd7, 5'd31, 11'h000});
    send_word({OPC_COP1, RS_MFC1, 5'd1, 5'd2, 11'h000});
    send_word({OPC_COP1, RS_MTC1, 5'd7, 5'd3, 5'd1, FN1_MOVE});
    send_word({OPC_COP1, RS_MFC1, 5'd1, 5'd2, 5'h10, FN1_MOVE});
    send_word({OPC_COP1, RS_UNUSED, 10'h0, 11'h000});
    send_word({OPC_COP1, 20'h0, FN1_UNUSED});
    // BEQL shares BEQ's number with the likely bit
    send_word({OPC_BEQL, 5'd1, 5'd2, 16'hFFFC});
    send_word({OPC_BEQ, 5'd1, 5'd2, 16'hFFFC});
    send_word({OPC_COP0, 26'h000_0038});
    send_word({OPC_UNUSED, 26'h0});
  endtask

  task automatic test_every_operation();
    for (int unsigned f = 0; f <= 48; f++) send_word(legal_word(f, $urandom));
    wait_drained();
  endtask

  // Mostly legal words, mixed with near misses and raw noise
  task automatic test_random_mix(input int idle, input int stall, input int count);
    int r;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 70) send_word(legal_word($urandom_range(48), $urandom));
      else if (r < 85) send_word(near_miss_word($urandom));
      else send_word($urandom);
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_special_cases();
    test_every_operation();
    test_random_mix(0, 0, 240);
    test_random_mix(69, 0, 240);
    test_random_mix(0, 69, 240);
    test_random_mix(14, 14, 240);
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0 && decoded_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/msid_pkg.sv
rtl/msid_decode.sv
rtl/mips_subset_instruction_decoder_unit.sv
rtl/msid_checker.sv
tb/tb_mips_subset_instruction_decoder_unit.sv
